[src/assert_macros.svh]
// Assertion helpers for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/lpsa_pkg.sv]
package lpsa_pkg;

    // Fixed field widths.
    localparam int REQ_W  = 16;
    localparam int LEN_W  = 12;
    localparam int OFS_W  = 16;
    // Wide enough for a request plus a header, and for a whole page.
    localparam int CALC_W = 18;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd512;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NO_ROOM  = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode          opcode;
        logic [REQ_W-1:0] req_len;
    } t_in_beat;

    typedef struct packed {
        t_status          status;
        logic [OFS_W-1:0] data_offset;
        logic [LEN_W-1:0] freed_len;
        logic             page_grow;
        logic             page_release;
    } t_out_beat;

    // Shift command broadcast to every stack cell.
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_cmd;

endpackage

[src/lifo_page_stack_allocator.sv]
// A result beat passes through the request register and then the output register.
// Only one item is held at a time; each item is first registered, then
// executed against the top two stack cells, which shift down or up together.
// Reset: clears the counters, top header offset, beat valid flags, and sets the
// length limit to 512. The stack cells are not reset; no clearing pass is needed.
`include "assert_macros.svh"

module lifo_page_stack_allocator #(
    parameter int PAGE_BYTES   = 4096,
    parameter int HEADER_BYTES = 16,
    parameter int STACK_DEPTH  = 256,
    parameter int MAX_PAGES    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [11:0]           i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  lpsa_pkg::t_in_beat    i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output lpsa_pkg::t_out_beat   o_out_beat
);
    import lpsa_pkg::*;

    localparam int RW      = $clog2(PAGE_BYTES);
    localparam int ENTRY_W = LEN_W + RW + 1;
    localparam int CW      = $clog2(STACK_DEPTH + 1);
    localparam int PW      = $clog2(MAX_PAGES + 1);

    // Configuration register.
    logic [LEN_W-1:0]  r_max_len;

    // Request register.
    logic              r_req_vld;
    t_opcode           r_req_op;
    logic [LEN_W-1:0]  r_req_len;
    logic [CALC_W-1:0] r_need;
    logic              r_too_long;

    // Allocator state.
    logic [CW-1:0]     r_count;
    logic [PW-1:0]     r_pages;
    logic [OFS_W-1:0]  r_top_hdr;
    logic [CW-1:0]     n_count;
    logic [PW-1:0]     n_pages;
    logic [OFS_W-1:0]  n_top_hdr;

    // Output register.
    logic              r_out_vld;
    t_out_beat         r_out;
    t_out_beat         n_out;

    logic              in_accept;
    logic              exec;
    logic [CALC_W-1:0] need_in;
    logic              too_long_in;

    t_stack_cmd        cmd;
    logic [ENTRY_W-1:0] push_entry;
    logic [ENTRY_W-1:0] w_entry [STACK_DEPTH];

    logic              empty;
    logic              full;
    logic              no_pages;
    logic              grow;
    logic [LEN_W-1:0]  top_len;
    logic [RW-1:0]     top_rem;
    logic              top_grow;
    logic [LEN_W-1:0]  next_len;
    logic [OFS_W-1:0]  hdr;
    logic [CALC_W-1:0] rem_full;

    // Configuration write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    // One item is held at a time; the output register decouples the sides.
    assign o_in_stall = r_req_vld;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign exec       = r_req_vld && (!r_out_vld || !i_out_stall);

    // Length checks are done while the beat is captured.
    assign need_in     = CALC_W'(i_in_beat.req_len) + CALC_W'(HEADER_BYTES);
    assign too_long_in = (i_in_beat.req_len > REQ_W'(r_max_len))
                      || (need_in > CALC_W'(PAGE_BYTES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else if (in_accept) begin
            r_req_vld <= 1'b1;
        end else if (exec) begin
            r_req_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req_op   <= i_in_beat.opcode;
            r_req_len  <= i_in_beat.req_len[LEN_W-1:0];
            r_need     <= need_in;
            r_too_long <= too_long_in;
        end
    end

    // Top two cells seen at fixed places.
    assign top_len  = w_entry[0][ENTRY_W-1 -: LEN_W];
    assign top_rem  = w_entry[0][RW:1];
    assign top_grow = w_entry[0][0];
    assign next_len = w_entry[1][ENTRY_W-1 -: LEN_W];

    assign empty    = (r_count == '0);
    assign full     = (r_count >= CW'(STACK_DEPTH));
    assign no_pages = (r_pages >= PW'(MAX_PAGES));

    // A new page is claimed for the first block or when the block does not fit.
    assign grow = empty || (r_need > CALC_W'(top_rem));
    assign hdr  = empty ? '0
                        : r_top_hdr + OFS_W'(HEADER_BYTES) + OFS_W'(top_len);

    // Bytes left in the page after the new block.
    assign rem_full = (grow ? CALC_W'(PAGE_BYTES) : '0)
                    + (empty ? '0 : CALC_W'(top_rem)) - r_need;

    // The grow flag doubles as the release flag when the block is popped.
    assign push_entry = {r_req_len, rem_full[RW-1:0], grow};

    // Operation decode and next state.
    always_comb begin
        cmd       = '0;
        n_out     = '0;
        n_count   = r_count;
        n_pages   = r_pages;
        n_top_hdr = r_top_hdr;
        unique case (r_req_op)
            OP_ALLOC: begin
                priority if (r_too_long) begin
                    n_out.status = ST_TOO_LONG;
                end else if (full) begin
                    n_out.status = ST_NO_ROOM;
                end else if (grow && no_pages) begin
                    n_out.status = ST_NO_ROOM;
                end else begin
                    cmd.push          = exec;
                    n_out.status      = ST_OK;
                    n_out.data_offset = hdr + OFS_W'(HEADER_BYTES);
                    n_out.page_grow   = grow;
                    n_count           = r_count + CW'(1);
                    n_top_hdr         = hdr;
                    if (grow) begin
                        n_pages = r_pages + PW'(1);
                    end
                end
            end
            OP_FREE: begin
                if (empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    cmd.pop            = exec;
                    n_out.status       = ST_OK;
                    n_out.freed_len    = top_len;
                    n_out.page_release = top_grow;
                    n_count            = r_count - CW'(1);
                    n_top_hdr          = (r_count >= CW'(2))
                        ? r_top_hdr - OFS_W'(HEADER_BYTES) - OFS_W'(next_len)
                        : '0;
                    if (top_grow && (r_pages != '0)) begin
                        n_pages = r_pages - PW'(1);
                    end
                end
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_pages   <= '0;
            r_top_hdr <= '0;
        end else if (exec) begin
            r_count   <= n_count;
            r_pages   <= n_pages;
            r_top_hdr <= n_top_hdr;
        end
    end

    // Result beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (exec) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

    // Row of stack cells, top of stack in cell zero.
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [ENTRY_W-1:0] above;
        logic [ENTRY_W-1:0] below;
        if (g == 0) begin : g_first
            assign above = push_entry;
        end else begin : g_mid_above
            assign above = w_entry[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_last
            assign below = '0;
        end else begin : g_mid_below
            assign below = w_entry[g+1];
        end
        lpsa_cell #(
            .ENTRY_W(ENTRY_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_from_above(above),
            .i_from_below(below),
            .o_entry     (w_entry[g])
        );
    end

    // Checks.
    `ASSERT_IMPLIES(a_pages_bound, i_clk, i_rst_n, 1'b1, r_pages <= PW'(MAX_PAGES))
    `ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(STACK_DEPTH))
    `ASSERT_IMPLIES(a_empty_hdr, i_clk, i_rst_n, r_count == '0, r_top_hdr == '0)
    `ASSERT_NEXT(a_exec_out, i_clk, i_rst_n, exec, r_out_vld)
    `ASSERT_NEXT(a_grow_page, i_clk, i_rst_n, cmd.push && grow, r_pages == $past(r_pages) + PW'(1))

endmodule

[src/lpsa_cell.sv]
module lpsa_cell #(
    parameter int ENTRY_W = 25
) (
    input  logic                i_clk,
    input  lpsa_pkg::t_stack_cmd i_cmd,
    input  logic [ENTRY_W-1:0]  i_from_above,
    input  logic [ENTRY_W-1:0]  i_from_below,
    output logic [ENTRY_W-1:0]  o_entry
);
    import lpsa_pkg::*;

    logic [ENTRY_W-1:0] r_entry;

    // A push moves every entry one cell deeper; a pop moves it one cell up.
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.push) begin
            r_entry <= i_from_above;
        end else if (i_cmd.pop) begin
            r_entry <= i_from_below;
        end else begin
            r_entry <= r_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

[tb/sv/tb_lifo_page_stack_allocator.sv]
`timescale 1ns / 100ps

module tb_lifo_page_stack_allocator;
    import lpsa_pkg::*;

    localparam int PAGE_B     = 4096;
    localparam int HDR_B      = 16;
    localparam int DEPTH      = 256;
    localparam int MAXP       = 16;
    localparam int HOLD_CYCLES = 250;

    // One row of the directed table: either a limit write or a request beat.
    typedef struct {
        bit              is_cfg;
        logic [11:0]     cfg_val;
        t_in_beat        beat;
        bit              typed;
        t_out_beat       want;
    } t_plan_row;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [11:0] cfg_data = '0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in_beat   in_beat   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_beat  out_beat;

    // Shadow copy of the allocator state.
    logic [LEN_W-1:0] blk_len  [DEPTH];
    logic [11:0]      blk_room [DEPTH];
    logic [15:0]      top_hdr   = '0;
    logic [8:0]       blk_count = '0;
    logic [4:0]       pages     = '0;
    logic [11:0]      len_limit = MAX_LEN_RESET;

    t_out_beat pending_results[$];
    t_out_beat head_beat;
    t_plan_row plan[$];
    int        mismatches = 0;
    bit        send_gaps   = 1'b1;
    bit        recv_stalls = 1'b1;
    bit        hold_req    = 1'b0;

    lifo_page_stack_allocator #(
        .PAGE_BYTES  (PAGE_B),
        .HEADER_BYTES(HDR_B),
        .STACK_DEPTH (DEPTH),
        .MAX_PAGES   (MAXP)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_beat  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_beat (out_beat)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Applies one request to the shadow state and returns the result it causes.
    function automatic t_out_beat step_allocator(t_in_beat b);
        t_out_beat   r;
        int unsigned len, need, hdr, room, prev_room, blk_end, bound;
        logic        grow, rel;
        r = '0;
        r.status = ST_OK;
        if (b.opcode == OP_ALLOC) begin
            len  = b.req_len;
            need = len + HDR_B;
            if (len > len_limit || need > PAGE_B) begin
                r.status = ST_TOO_LONG;
            end else if (blk_count >= DEPTH) begin
                r.status = ST_NO_ROOM;
            end else begin
                if (blk_count == 0) begin
                    grow = 1'b1;
                    hdr  = 0;
                    room = PAGE_B - need;
                end else begin
                    prev_room = blk_room[blk_count - 1];
                    hdr = top_hdr + HDR_B + blk_len[blk_count - 1];
                    if (need > prev_room) begin
                        grow = 1'b1;
                        room = PAGE_B - (need - prev_room);
                    end else begin
                        grow = 1'b0;
                        room = prev_room - need;
                    end
                end
                if (grow && pages >= MAXP) begin
                    r.status = ST_NO_ROOM;
                end else begin
                    if (grow) pages++;
                    blk_len[blk_count]  = LEN_W'(len);
                    blk_room[blk_count] = 12'(room);
                    blk_count++;
                    top_hdr = 16'(hdr);
                    r.data_offset = 16'(hdr + HDR_B);
                    r.page_grow = grow;
                end
            end
        end else if (blk_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            len     = blk_len[blk_count - 1];
            hdr     = top_hdr;
            blk_end = hdr + HDR_B + len;
            // Next page boundary at or above the header.
            bound = (hdr / PAGE_B) * PAGE_B;
            if (bound != hdr) bound += PAGE_B;
            rel = (blk_count == 1) || (bound == hdr) || (bound < blk_end);
            if (blk_count >= 2) begin
                top_hdr = 16'(hdr - HDR_B - blk_len[blk_count - 2]);
            end else begin
                top_hdr = '0;
            end
            blk_count--;
            if (rel && pages > 0) pages--;
            r.freed_len = LEN_W'(len);
            r.page_release = rel;
        end
        return r;
    endfunction

    function automatic t_in_beat make_beat(t_opcode op, int unsigned len);
        t_in_beat b;
        b.opcode  = op;
        b.req_len = REQ_W'(len);
        return b;
    endfunction

    function automatic t_plan_row pred_row(t_opcode op, int unsigned len);
        t_plan_row p;
        p.is_cfg  = 1'b0;
        p.cfg_val = '0;
        p.beat    = make_beat(op, len);
        p.typed   = 1'b0;
        p.want    = '0;
        return p;
    endfunction

    function automatic t_plan_row known_row(t_opcode op, int unsigned len, t_status st,
                                            int unsigned offs, int unsigned flen,
                                            bit grow, bit rel);
        t_plan_row p;
        p = pred_row(op, len);
        p.typed = 1'b1;
        p.want.status       = st;
        p.want.data_offset  = OFS_W'(offs);
        p.want.freed_len    = LEN_W'(flen);
        p.want.page_grow    = grow;
        p.want.page_release = rel;
        return p;
    endfunction

    function automatic t_plan_row limit_row(int unsigned v);
        t_plan_row p;
        p = pred_row(OP_ALLOC, 0);
        p.is_cfg  = 1'b1;
        p.cfg_val = 12'(v);
        return p;
    endfunction

    // Offers one request beat, waits for it to be taken and records its expected result.
    task automatic offer_beat(input t_in_beat b, input bit typed, input t_out_beat want);
        t_out_beat predicted;
        @(negedge clk);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do begin
            @(posedge clk);
        end while (in_stall);
        predicted = step_allocator(b);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic offer_req(input t_opcode op, input int unsigned len);
        offer_beat(make_beat(op, len), 1'b0, '0);
    endtask

    // Stops sending and waits until every result beat has come back.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_limit(input logic [11:0] v);
        settle();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        len_limit = v;
    endtask

    // Random mix of allocates and frees, with some rejected lengths.
    task automatic run_mixed(input int n);
        int unsigned len;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(0, 65535);
                1:       len = len_limit + $urandom_range(0, 1);
                default: len = $urandom_range(0, len_limit);
            endcase
            offer_req(($urandom_range(0, 99) < 58) ? OP_ALLOC : OP_FREE, len);
        end
    endtask

    // Frees every block and then one more on the empty stack.
    task automatic free_all();
        repeat (blk_count + 1) offer_req(OP_FREE, $urandom_range(0, 65535));
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    // Receiver side: random stall bursts, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end else if (recv_stalls && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: result beat with none expected, expected none, actual %p",
                         $time, out_beat);
            end else begin
                head_beat = pending_results.pop_front();
                check_field("status", head_beat.status, out_beat.status);
                check_field("data_offset", head_beat.data_offset, out_beat.data_offset);
                check_field("freed_len", head_beat.freed_len, out_beat.freed_len);
                check_field("page_grow", head_beat.page_grow, out_beat.page_grow);
                check_field("page_release", head_beat.page_release, out_beat.page_release);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int unsigned tries;

        // Directed table, starting from the reset limit of 512.
        plan.push_back(known_row(OP_FREE, 16'hA5A5, ST_EMPTY, 0, 0, 0, 0));
        plan.push_back(known_row(OP_ALLOC, 0, ST_OK, 16, 0, 1, 0));
        plan.push_back(known_row(OP_ALLOC, 512, ST_OK, 32, 0, 0, 0));
        plan.push_back(known_row(OP_ALLOC, 513, ST_TOO_LONG, 0, 0, 0, 0));
        plan.push_back(known_row(OP_ALLOC, 65535, ST_TOO_LONG, 0, 0, 0, 0));
        plan.push_back(pred_row(OP_FREE, 16'hFFFF));
        plan.push_back(known_row(OP_FREE, 0, ST_OK, 0, 0, 0, 1));
        plan.push_back(known_row(OP_FREE, 16'h5A5A, ST_EMPTY, 0, 0, 0, 0));
        plan.push_back(limit_row(4080));
        plan.push_back(known_row(OP_ALLOC, 4080, ST_OK, 16, 0, 1, 0));
        plan.push_back(pred_row(OP_ALLOC, 4080));
        plan.push_back(pred_row(OP_ALLOC, 100));
        plan.push_back(pred_row(OP_ALLOC, 2000));
        plan.push_back(pred_row(OP_ALLOC, 3000));
        plan.push_back(known_row(OP_ALLOC, 4081, ST_TOO_LONG, 0, 0, 0, 0));
        repeat (5) plan.push_back(pred_row(OP_FREE, 16'h1234));
        plan.push_back(known_row(OP_FREE, 0, ST_EMPTY, 0, 0, 0, 0));
        plan.push_back(limit_row(0));
        plan.push_back(known_row(OP_ALLOC, 0, ST_OK, 16, 0, 1, 0));
        plan.push_back(known_row(OP_ALLOC, 1, ST_TOO_LONG, 0, 0, 0, 0));
        plan.push_back(known_row(OP_FREE, 0, ST_OK, 0, 0, 0, 1));

        // Hold reset, then release it at a falling clock edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                write_limit(plan[i].cfg_val);
            end else begin
                offer_beat(plan[i].beat, plan[i].typed, plan[i].want);
            end
        end

        // Large blocks until the page limit is reached, then unwind.
        write_limit(4080);
        repeat (28) offer_req(OP_ALLOC, $urandom_range(3000, 4080));
        free_all();

        // Small blocks until the stack is full, with the receiver held off.
        write_limit($urandom_range(0, 120));
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        hold_req    = 1'b1;
        tries = 0;
        while (blk_count < DEPTH && tries < 400) begin
            if ($urandom_range(0, 19) == 0) begin
                offer_req(OP_ALLOC, len_limit + 1 + $urandom_range(0, 3000));
            end else begin
                offer_req(OP_ALLOC, $urandom_range(0, len_limit));
            end
            tries++;
        end
        repeat (3) offer_req(OP_ALLOC, $urandom_range(0, len_limit));
        free_all();

        // Mixed traffic under several limits and idling patterns.
        for (int k = 0; k < 5; k++) begin
            case (k)
                0:       write_limit(0);
                1:       write_limit(4080);
                2:       write_limit(512);
                default: write_limit($urandom_range(0, 4080));
            endcase
            send_gaps   = $urandom_range(0, 1);
            recv_stalls = $urandom_range(0, 1);
            run_mixed(32);
        end

        // Closing stretch runs with no idling on either side.
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        write_limit($urandom_range(1, 4080));
        run_mixed(30);
        free_all();

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
